[sv/mvdc_pkg.sv]
package mvdc_pkg;

   localparam int SP_W    = 7;
   localparam int TEMP_W  = 7;
   localparam int TICK_W  = 16;
   localparam int TPD_W   = 8;
   localparam int PHASE_W = 3;
   localparam int IDX_W   = 8;
   localparam int CSR_W   = 16;
   localparam int REQ_W   = 16;
   localparam int RSP_W   = 8;

   // register indexes on the csr port
   localparam logic [IDX_W-1:0] REG_SETPOINT = 8'd0;
   localparam logic [IDX_W-1:0] REG_DEADBAND = 8'd1;
   localparam logic [IDX_W-1:0] REG_WAIT     = 8'd2;
   localparam logic [IDX_W-1:0] REG_TPD      = 8'd3;

   // reset values of the registers
   localparam logic [SP_W-1:0]   SETPOINT_RST = 7'd40;
   localparam logic [SP_W-1:0]   DEADBAND_RST = 7'd2;
   localparam logic [TICK_W-1:0] WAIT_RST     = 16'd60;
   localparam logic [TPD_W-1:0]  TPD_RST      = 8'd10;

   // controller phases
   localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_WAIT  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_EVAL  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_ROT   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_FAULT = 3'd4;

   typedef struct packed {
      logic [SP_W-1:0]   setpoint;
      logic [SP_W-1:0]   deadband;
      logic [TICK_W-1:0] wait_ticks;
      logic [TPD_W-1:0]  ticks_per_degree;
   } mvdc_cfg_type;

   typedef struct packed {
      logic              tick;
      logic [TEMP_W-1:0] flow_temp;
      logic              module_present;
      logic              enable;
   } mvdc_item_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               drive_colder;
      logic               drive_warmer;
      logic               pump_on;
   } mvdc_result_type;

endpackage

[sv/mvdc_csr.sv]
module mvdc_csr
   import mvdc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic [IDX_W-1:0]        csr_index,
   input  logic [CSR_W-1:0]        csr_data,
   output mvdc_cfg_type            cfg
);

   mvdc_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_SETPOINT: cfg_in.setpoint         = csr_data[SP_W-1:0];
            REG_DEADBAND: cfg_in.deadband         = csr_data[SP_W-1:0];
            REG_WAIT:     cfg_in.wait_ticks       = csr_data[TICK_W-1:0];
            REG_TPD:      cfg_in.ticks_per_degree = csr_data[TPD_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint         <= SETPOINT_RST;
         cfg_ff.deadband         <= DEADBAND_RST;
         cfg_ff.wait_ticks       <= WAIT_RST;
         cfg_ff.ticks_per_degree <= TPD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/mvdc_in_reg.sv]
module mvdc_in_reg
   import mvdc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic          take,
   output logic          item_vld,
   output mvdc_item_type item
);

   logic          vld_ff, vld_in;
   mvdc_item_type item_ff;
   logic          accept;

   assign req_tready = !vld_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      vld_in = vld_ff;
      if (accept) begin
         vld_in = 1'b1;
      end else if (take) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= mvdc_item_type'(req_tdata[$bits(mvdc_item_type)-1:0]);
      end
   end

   assign item_vld = vld_ff;
   assign item     = item_ff;

endmodule

[sv/mvdc_core.sv]
module mvdc_core
   import mvdc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  mvdc_cfg_type    cfg,
   input  logic            item_vld,
   input  mvdc_item_type   item,
   output logic            take,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output mvdc_result_type result
);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [TICK_W-1:0]  elapsed_ff, elapsed_in;
   logic [TICK_W-1:0]  rotate_ff, rotate_in;
   logic               pump_ff, pump_in;
   logic               warmer_ff, warmer_in;
   logic               colder_ff, colder_in;
   logic               rsp_vld_ff, rsp_vld_in;

   logic [TICK_W-1:0]       elapsed_t;
   logic signed [SP_W+1:0]  lo, hi, flow_s;
   logic                    below, above;
   logic [TEMP_W-1:0]       err_mag;
   logic [TEMP_W+TPD_W-1:0] product;

   assign take = item_vld && (!rsp_vld_ff || rsp_tready);

   always_comb begin
      // band edges widened so they can go negative or past the field range
      lo      = $signed({2'b00, cfg.setpoint}) - $signed({2'b00, cfg.deadband});
      hi      = $signed({2'b00, cfg.setpoint}) + $signed({2'b00, cfg.deadband});
      flow_s  = $signed({2'b00, item.flow_temp});
      below   = flow_s < lo;
      above   = flow_s > hi;
      err_mag = below ? (cfg.setpoint - item.flow_temp) : (item.flow_temp - cfg.setpoint);
      product = err_mag * cfg.ticks_per_degree;

      // saturating tick timer advances before the phase step
      elapsed_t = (item.tick && (elapsed_ff != '1)) ? elapsed_ff + 1'b1 : elapsed_ff;

      phase_in   = phase_ff;
      elapsed_in = elapsed_t;
      rotate_in  = rotate_ff;
      pump_in    = pump_ff;
      warmer_in  = warmer_ff;
      colder_in  = colder_ff;

      case (phase_ff)
         PH_IDLE: begin
            if (item.enable) begin
               pump_in    = 1'b1;
               phase_in   = PH_WAIT;
               elapsed_in = '0;
            end
         end
         PH_WAIT: begin
            if (!item.enable) begin
               pump_in  = 1'b0;
               phase_in = PH_IDLE;
            end else if (!item.module_present) begin
               phase_in = PH_FAULT;
            end else if (elapsed_t >= cfg.wait_ticks) begin
               phase_in   = PH_EVAL;
               elapsed_in = '0;
            end
         end
         PH_EVAL: begin
            if (below) begin
               rotate_in = TICK_W'(product);
               warmer_in = 1'b1;
               phase_in  = PH_ROT;
            end else if (above) begin
               rotate_in = TICK_W'(product);
               colder_in = 1'b1;
               phase_in  = PH_ROT;
            end else begin
               phase_in = PH_WAIT;
            end
            elapsed_in = '0;
         end
         PH_ROT: begin
            // disable is ignored until the rotation has run out
            if (elapsed_t >= rotate_ff) begin
               phase_in   = PH_WAIT;
               elapsed_in = '0;
               warmer_in  = 1'b0;
               colder_in  = 1'b0;
            end
         end
         PH_FAULT: begin
            if (!item.enable) begin
               phase_in = PH_IDLE;
               pump_in  = 1'b0;
            end else if (item.module_present) begin
               phase_in   = PH_WAIT;
               elapsed_in = '0;
            end
         end
         default: begin
            phase_in = PH_FAULT;
         end
      endcase

      rsp_vld_in = rsp_vld_ff;
      if (take) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         elapsed_ff <= '0;
         rotate_ff  <= '0;
         pump_ff    <= 1'b0;
         warmer_ff  <= 1'b0;
         colder_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
         if (take) begin
            phase_ff   <= phase_in;
            elapsed_ff <= elapsed_in;
            rotate_ff  <= rotate_in;
            pump_ff    <= pump_in;
            warmer_ff  <= warmer_in;
            colder_ff  <= colder_in;
         end
      end
   end

   assign rsp_tvalid           = rsp_vld_ff;
   assign result.pump_on       = pump_ff;
   assign result.drive_warmer  = warmer_ff;
   assign result.drive_colder  = colder_ff;
   assign result.phase         = phase_ff;

endmodule

[sv/mixing_valve_deadband_control_top.sv]
// mixing valve deadband controller, one result word per request word
// request words pass the input reg, then the state/result reg, before the result is valid
// 1 word per cycle unless stalled; the phase step is one pass of compare and a 7x8 multiply
// a stalled result holds the pipe, request ready falls only when both stages are full
// reset (synchronous, active high): phase idle, timer and drives clear, pump off,
// registers back to setpoint 40, deadband 2, wait 60 ticks, 10 ticks per degree
module mixing_valve_deadband_control_top
   import mvdc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // enable, module_present, flow_temp[6:0], tick, zero pad
   // result channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // pump_on, drive_warmer, drive_colder, phase[2:0], zero pad
   // register write channel
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_data
);

   mvdc_cfg_type    cfg;
   mvdc_item_type   item;
   mvdc_result_type result;
   logic            item_vld;
   logic            take;

   // register writes are taken every cycle
   assign csr_ready = 1'b1;

   mvdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // first stage: request word register
   mvdc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .item_vld   (item_vld),
      .item       (item)
   );

   // second stage: phase machine, timer and result register
   mvdc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_vld   (item_vld),
      .item       (item),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .result     (result)
   );

   // pad result word to a whole byte
   assign rsp_tdata = {{(RSP_W - $bits(mvdc_result_type)){1'b0}}, result};

endmodule

[sv/mvdc_checker.sv]
module mvdc_checker
   import mvdc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // no result word right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // stalled result word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   // valve drives only while rotating, never both ways
   a_drive_rot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1] || rsp_tdata[2]) |->
         rsp_tdata[5:3] == PH_ROT && !(rsp_tdata[1] && rsp_tdata[2]))
      else $error("valve drive outside rotation");

   // pump is off whenever idle
   a_idle_pump: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[5:3] == PH_IDLE |-> !rsp_tdata[0])
      else $error("pump on while idle");

endmodule

bind mixing_valve_deadband_control_top mvdc_checker u_mvdc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
